FILE: hdl/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [2:0]      n_bytes;
        logic [CP_W-1:0] cp;
        logic            has_status;
        logic [3:0]      status;
    } jsu_entry_t;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NO_OPEN     = 4'd1;
    localparam logic [3:0] ST_END_ESC     = 4'd2;
    localparam logic [3:0] ST_END_HEX     = 4'd3;
    localparam logic [3:0] ST_BAD_HEX     = 4'd4;
    localparam logic [3:0] ST_NO_BSLASH   = 4'd5;
    localparam logic [3:0] ST_NO_U        = 4'd6;
    localparam logic [3:0] ST_NO_LOW      = 4'd7;
    localparam logic [3:0] ST_NO_CLOSE    = 4'd8;
    localparam logic [3:0] ST_TRAILING    = 4'd9;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] SURR_MASK = 16'hfc00;
    localparam logic [15:0] SURR_HIGH = 16'hd800;
    localparam logic [15:0] SURR_LOW  = 16'hdc00;
    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

endpackage

FILE: hdl/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       q_push,
    output jsu_entry_t q_entry
);

    typedef enum logic [3:0] {
        PH_OPEN,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_NEED_BS,
        PH_NEED_U,
        PH_HEX2,
        PH_CLOSED,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [9:0]  hi_reg, hi_next;
    logic [3:0]  err_reg, err_next;

    logic [3:0]      digit;
    logic            digit_ok;
    logic [15:0]     acc_sh;
    logic [2:0]      n_bytes;
    logic [CP_W-1:0] cp;
    logic [3:0]      st;
    logic [3:0]      fail_code;
    logic            fail_now;

    always_comb
    begin
        digit    = 4'd0;
        digit_ok = 1'b1;
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            digit = 4'(in_byte - 8'h30);
        end
        else if (in_byte >= 8'h61 && in_byte <= 8'h66)
        begin
            digit = 4'(in_byte - 8'h57);
        end
        else if (in_byte >= 8'h41 && in_byte <= 8'h46)
        begin
            digit = 4'(in_byte - 8'h37);
        end
        else
        begin
            digit_ok = 1'b0;
        end
    end

    assign acc_sh = {acc_reg[11:0], digit};

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        hi_next    = hi_reg;
        n_bytes    = 3'd0;
        cp         = {{(CP_W-8){1'b0}}, in_byte};
        fail_now   = 1'b0;
        fail_code  = ST_OK;

        unique case (phase_reg)
            PH_OPEN:
            begin
                if (in_byte == CH_QUOTE)
                    phase_next = PH_BODY;
                else
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_NO_OPEN;
                end
            end
            PH_BODY:
            begin
                if (in_byte == CH_QUOTE)
                    phase_next = PH_CLOSED;
                else if (in_byte == CH_BSLASH)
                    phase_next = PH_ESC;
                else
                    n_bytes = 3'd1;
            end
            PH_ESC:
            begin
                phase_next = PH_BODY;
                n_bytes    = 3'd1;
                unique case (in_byte)
                    CH_B: cp = CP_W'(8'h08);
                    CH_F: cp = CP_W'(8'h0c);
                    CH_N: cp = CP_W'(8'h0a);
                    CH_R: cp = CP_W'(8'h0d);
                    CH_T: cp = CP_W'(8'h09);
                    CH_U:
                    begin
                        phase_next = PH_HEX1;
                        acc_next   = 16'd0;
                        cnt_next   = 2'd0;
                        n_bytes    = 3'd0;
                    end
                    default: cp = {{(CP_W-8){1'b0}}, in_byte};
                endcase
            end
            PH_HEX1:
            begin
                if (!digit_ok)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_BAD_HEX;
                end
                else if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    acc_next = 16'd0;
                    if ((acc_sh & SURR_MASK) == SURR_HIGH)
                    begin
                        hi_next    = acc_sh[9:0];
                        phase_next = PH_NEED_BS;
                    end
                    else
                    begin
                        cp         = {{(CP_W-16){1'b0}}, acc_sh};
                        phase_next = PH_BODY;
                        if (acc_sh <= 16'h007f)
                            n_bytes = 3'd1;
                        else if (acc_sh <= 16'h07ff)
                            n_bytes = 3'd2;
                        else
                            n_bytes = 3'd3;
                    end
                end
                else
                begin
                    acc_next = acc_sh;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            PH_NEED_BS:
            begin
                if (in_byte == CH_BSLASH)
                    phase_next = PH_NEED_U;
                else
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_NO_BSLASH;
                end
            end
            PH_NEED_U:
            begin
                if (in_byte == CH_U)
                begin
                    phase_next = PH_HEX2;
                    acc_next   = 16'd0;
                    cnt_next   = 2'd0;
                end
                else
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_NO_U;
                end
            end
            PH_HEX2:
            begin
                if (!digit_ok)
                begin
                    fail_now  = 1'b1;
                    fail_code = ST_BAD_HEX;
                end
                else if (cnt_reg == 2'd3)
                begin
                    cnt_next = 2'd0;
                    acc_next = 16'd0;
                    if ((acc_sh & SURR_MASK) != SURR_LOW)
                    begin
                        fail_now  = 1'b1;
                        fail_code = ST_NO_LOW;
                    end
                    else
                    begin
                        cp         = SUPP_BASE + {1'b0, hi_reg, acc_sh[9:0]};
                        n_bytes    = 3'd4;
                        phase_next = PH_BODY;
                    end
                end
                else
                begin
                    acc_next = acc_sh;
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            PH_CLOSED:
            begin
                fail_now  = 1'b1;
                fail_code = ST_TRAILING;
            end
            default:
            begin
                phase_next = PH_ERROR;
            end
        endcase

        err_next = err_reg;
        if (fail_now)
        begin
            phase_next = PH_ERROR;
            if (err_reg == ST_OK)
                err_next = fail_code;
        end

        st = err_next;
        if (err_next == ST_OK)
        begin
            unique case (phase_next)
                PH_OPEN:    st = ST_NO_OPEN;
                PH_BODY:    st = ST_NO_CLOSE;
                PH_ESC:     st = ST_END_ESC;
                PH_HEX1:    st = ST_END_HEX;
                PH_HEX2:    st = ST_END_HEX;
                PH_NEED_BS: st = ST_NO_BSLASH;
                PH_NEED_U:  st = ST_NO_U;
                default:    st = ST_OK;
            endcase
        end
    end

    assign q_push             = accept && (n_bytes != 3'd0 || end_of_string);
    assign q_entry.n_bytes    = n_bytes;
    assign q_entry.cp         = cp;
    assign q_entry.has_status = end_of_string;
    assign q_entry.status     = end_of_string ? st : ST_OK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_OPEN;
            acc_reg   <= 16'd0;
            cnt_reg   <= 2'd0;
            hi_reg    <= 10'd0;
            err_reg   <= ST_OK;
        end
        else if (accept)
        begin
            if (end_of_string)
            begin
                phase_reg <= PH_OPEN;
                acc_reg   <= 16'd0;
                cnt_reg   <= 2'd0;
                hi_reg    <= 10'd0;
                err_reg   <= ST_OK;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                hi_reg    <= hi_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

FILE: hdl/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  jsu_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output jsu_entry_t head,
    output logic       empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jsu_entry_t    slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == CW'(0));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  jsu_entry_t head,
    input  logic       q_empty,
    output logic       q_pop,
    input  logic       pop,
    output logic       empty,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic [3:0] status,
    output logic       last
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic [3:0] status_reg;
    logic       last_reg;

    logic [2:0] total;
    logic       load;
    logic       item_last;
    logic       item_kind;
    logic [7:0] item_byte;
    logic [3:0] item_status;

    assign total     = head.n_bytes + {2'b00, head.has_status};
    assign load      = (!valid_reg || (pop && valid_reg)) && !q_empty;
    assign item_last = (idx_reg == total - 3'd1);
    assign q_pop     = load && item_last;
    assign idx_next  = item_last ? 3'd0 : idx_reg + 3'd1;

    always_comb
    begin
        item_kind   = KIND_DATA;
        item_byte   = 8'h00;
        item_status = ST_OK;
        if (idx_reg == head.n_bytes)
        begin
            item_kind   = KIND_STATUS;
            item_status = head.status;
        end
        else
        begin
            unique case (head.n_bytes)
                3'd1: item_byte = head.cp[7:0];
                3'd2:
                begin
                    unique case (idx_reg)
                        3'd0:    item_byte = {3'b110, head.cp[10:6]};
                        default: item_byte = {2'b10, head.cp[5:0]};
                    endcase
                end
                3'd3:
                begin
                    unique case (idx_reg)
                        3'd0:    item_byte = {4'b1110, head.cp[15:12]};
                        3'd1:    item_byte = {2'b10, head.cp[11:6]};
                        default: item_byte = {2'b10, head.cp[5:0]};
                    endcase
                end
                3'd4:
                begin
                    unique case (idx_reg)
                        3'd0:    item_byte = {5'b11110, head.cp[20:18]};
                        3'd1:    item_byte = {2'b10, head.cp[17:12]};
                        3'd2:    item_byte = {2'b10, head.cp[11:6]};
                        default: item_byte = {2'b10, head.cp[5:0]};
                    endcase
                end
                default: item_byte = 8'h00;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= item_kind;
            byte_reg   <= item_byte;
            status_reg <= item_status;
            last_reg   <= item_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end
            else if (pop && valid_reg)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign empty    = !valid_reg;
    assign out_kind = kind_reg;
    assign out_byte = byte_reg;
    assign status   = status_reg;
    assign last     = last_reg;

    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> idx_reg == 3'd0)
        else $error("sub-item index left nonzero with no pending entry");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> idx_reg < total)
        else $error("sub-item index past the entry's item count");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg == KIND_STATUS) |-> last_reg)
        else $error("status item not marked last");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !item_last) |=> idx_reg == $past(idx_reg) + 3'd1)
        else $error("sub-item index did not advance");

endmodule

FILE: hdl/json_string_unescape_to_utf8.sv
// Path: a transfer writes its result into a queue slot; the back end then loads it into
// the output register, which holds while an earlier result there is not yet popped.
// Throughput: one input per cycle until full rises; an input yielding k results holds
// the back end until all k are loaded; up to QUEUE_DEPTH entries absorb multi-byte bursts.
// Output: one result per cycle while pop stays high and results are pending.
// Reset: asynchronous, active low; clears parse state, queue pointers and output valid.
`timescale 1ns / 1ps

module json_string_unescape_to_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       empty,
    input  logic       pop,
    output logic       out_kind,
    output logic [7:0] out_byte,
    output logic [3:0] status,
    output logic       last
);

    jsu_entry_t q_entry;
    jsu_entry_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       accept;

    assign accept = push && !full;

    jsu_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    jsu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_kind (out_kind),
        .out_byte (out_byte),
        .status   (status),
        .last     (last)
    );

endmodule
